FILE: sv/bbrk_pkg.sv
// Shared types and constants for the buck/boost RK4 plant step block.
package bbrk_pkg;

	// Sequencer states of the step engine
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DV,
		ST_PT,
		ST_LOAD,
		ST_OMV,
		ST_OMI,
		ST_AB,
		ST_KI,
		ST_KV,
		ST_ACC,
		ST_DSET,
		ST_DIV,
		ST_UPD
	} st_t;

	// Right shift applied to a product by the shared multiplier
	typedef enum logic [1:0] {
		SH16,
		SH24,
		SH32
	} sh_t;

	// Request from the sequencer to the shared multiplier
	typedef struct packed {
		logic start;
		sh_t  sh;
		logic sat;
	} mul_req_t;

	// Register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_STEP_L = 2'd0,
		REG_STEP_C = 2'd1,
		REG_LOAD_G = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;

	localparam logic [31:0] STEP_L_RST = 32'd42949673;
	localparam logic [31:0] STEP_C_RST = 32'd42949673;
	localparam logic [31:0] LOAD_G_RST = 32'd1677722;
	localparam logic [16:0] FRAC_ONE   = 17'h10000;
	// ceil(2^13 / 6): exact quotient by six for any 11-bit partial dividend
	localparam logic [10:0] RECIP_SIX  = 11'd1366;

endpackage

FILE: sv/bbrk_in_if.sv
// Input channel interface: duty, mode and supply voltage of one item.
interface bbrk_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] duty;
	logic        mode;
	logic [31:0] v_in;

	modport source(output valid, output duty, output mode, output v_in, input ready);
	modport sink(input valid, input duty, input mode, input v_in, output ready);
endinterface

FILE: sv/bbrk_out_if.sv
// Output channel interface: inductor current and capacitor voltage after a step.
interface bbrk_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] i_l;
	logic [31:0] v_c;

	modport source(output valid, output i_l, output v_c, input ready);
	modport sink(input valid, input i_l, input v_c, output ready);
endinterface

FILE: sv/bbrk_mul.sv
// Shared sign-magnitude multiplier: 32x32 core used twice per product, then shift and saturate.
module bbrk_mul #(
	parameter int STATE_WIDTH = 32,
	parameter int AW = 38
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bbrk_pkg::mul_req_t   req,
	input  logic signed [AW-1:0] opa,
	input  logic [31:0]          opb,
	output logic                 done,
	output logic signed [AW-1:0] res
);
	import bbrk_pkg::*;

	localparam logic [95:0] LIM_W = 96'((97'd1 << (STATE_WIDTH + 2)) - 97'd1);
	localparam logic signed [AW-1:0] LIM_A = AW'(LIM_W);

	logic [1:0]           ph_q;
	logic                 done_q;
	logic [63:0]          mag_q;
	logic                 neg_q;
	logic [31:0]          b_q;
	sh_t                  sh_q;
	logic                 sat_q;
	logic [63:0]          prod_q;
	logic [63:0]          lo_q;
	logic signed [AW-1:0] res_q;

	logic signed [AW-1:0] sa_c;
	logic signed [AW-1:0] mag_c;
	logic [95:0]          full_c;
	logic [95:0]          shf_c;
	logic [AW-1:0]        rmag_c;
	logic signed [AW-1:0] fin_c;

	// Saturate the operand, then take its magnitude
	always_comb begin
		if (opa > LIM_A) begin
			sa_c = LIM_A;
		end else if (opa < -LIM_A) begin
			sa_c = -LIM_A;
		end else begin
			sa_c = opa;
		end
		mag_c = (sa_c < 0) ? -sa_c : sa_c;
	end

	// Combine both partial products, shift, saturate, restore sign
	always_comb begin
		full_c = {prod_q, 32'd0} + {32'd0, lo_q};
		unique case (sh_q)
			SH16:    shf_c = full_c >> 16;
			SH24:    shf_c = full_c >> 24;
			SH32:    shf_c = full_c >> 32;
			default: shf_c = full_c >> 32;
		endcase
		if (sat_q && (shf_c > LIM_W)) begin
			rmag_c = AW'(LIM_W);
		end else begin
			rmag_c = shf_c[AW-1:0];
		end
		fin_c = neg_q ? -signed'(rmag_c) : signed'(rmag_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= (ph_q == 2'd3);
			if (ph_q == 2'd0) begin
				if (req.start) begin
					ph_q <= 2'd1;
				end
			end else begin
				ph_q <= ph_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (ph_q)
			2'd0: begin
				if (req.start) begin
					mag_q <= 64'(unsigned'(mag_c));
					neg_q <= (sa_c < 0);
					b_q   <= opb;
					sh_q  <= req.sh;
					sat_q <= req.sat;
				end
			end
			2'd1: prod_q <= mag_q[31:0] * b_q;
			2'd2: begin
				lo_q   <= prod_q;
				prod_q <= mag_q[63:32] * b_q;
			end
			2'd3: res_q <= fin_c;
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

FILE: sv/buck_boost_rk4_plant_step_top.sv
// Averaged buck/boost converter plant advanced by one RK4 step per input item.
// The divide by six runs ND = ceil(AW / 8) divide steps (AW = STATE_WIDTH + 6, at
// least 34). A new item is taken only once the last one has left the step engine; the
// shared 32x32 multiplier and the byte-a-cycle divide by six set the pace. A full
// output register holds the block in its last state.
// Reset (arst_n, asynchronous, active low) clears both states to zero and loads
// the register reset values; no clearing pass is needed.
module buck_boost_rk4_plant_step_top #(
	parameter int STATE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	bbrk_in_if.sink     in,
	bbrk_out_if.source  out
);
	import bbrk_pkg::*;

	// Internal signed width: room for six times the stage limit and a 32-bit product
	localparam int AW = (STATE_WIDTH + 6 > 34) ? STATE_WIDTH + 6 : 34;
	// Dividend padded to whole bytes, one byte per divide step
	localparam int DW = ((AW + 7) / 8) * 8;
	localparam int ND = DW / 8;
	localparam int CW = $clog2(ND + 1);
	localparam logic signed [AW-1:0] LIM_A = AW'((66'd1 << (STATE_WIDTH + 2)) - 66'd1);
	localparam logic signed [AW-1:0] SMAX  = AW'((66'd1 << STATE_WIDTH) - 66'd1);

	// Configuration registers
	logic [31:0] step_l_q;
	logic [31:0] step_c_q;
	logic [31:0] load_g_q;

	// Sequencer
	st_t        st_q;
	st_t        st_d;
	logic [1:0] stage_q;
	logic       issued_q;

	// Item and plant state
	logic [15:0]            duty_q;
	logic                   boost_q;
	logic [31:0]            vin_q;
	logic [STATE_WIDTH-1:0] i0_q;
	logic [STATE_WIDTH-1:0] v0_q;

	// Stage working values
	logic signed [AW-1:0] dv_q;
	logic signed [AW-1:0] ci_q;
	logic signed [AW-1:0] vp_q;
	logic signed [AW-1:0] load_q;
	logic signed [AW-1:0] omv_q;
	logic signed [AW-1:0] omi_q;
	logic signed [AW-1:0] da_q;
	logic signed [AW-1:0] db_q;
	logic signed [AW-1:0] ki_q;
	logic signed [AW-1:0] kv_q;
	logic signed [AW-1:0] si_q;
	logic signed [AW-1:0] sv_q;

	// Divide by six
	logic [DW-1:0] qi_q;
	logic [DW-1:0] qv_q;
	logic [2:0]    ri_q;
	logic [2:0]    rv_q;
	logic          negi_q;
	logic          negv_q;
	logic [CW-1:0] cnt_q;

	// Output register
	logic        out_valid_q;
	logic [31:0] out_i_q;
	logic [31:0] out_v_q;

	// Multiplier hookup
	mul_req_t             mreq;
	logic signed [AW-1:0] mopa;
	logic [31:0]          mopb;
	logic                 mdone;
	logic signed [AW-1:0] mres;

	logic                   in_fire;
	logic                   out_fire;
	logic                   cfg_wr;
	logic                   upd_fire;
	logic [16:0]            omd;
	logic signed [AW-1:0]   i0_x;
	logic signed [AW-1:0]   v0_x;
	logic signed [AW-1:0]   khi_c;
	logic signed [AW-1:0]   khv_c;
	logic signed [AW-1:0]   pi_c;
	logic signed [AW-1:0]   pv_c;
	logic [10:0]            rti_c;
	logic [10:0]            rtv_c;
	logic [21:0]            mqi_c;
	logic [21:0]            mqv_c;
	logic [7:0]             qdi_c;
	logic [7:0]             qdv_c;
	logic [10:0]            sxi_c;
	logic [10:0]            sxv_c;
	logic [10:0]            rmi_c;
	logic [10:0]            rmv_c;
	logic signed [AW-1:0]   qsi_c;
	logic signed [AW-1:0]   qsv_c;
	logic signed [AW-1:0]   ni_c;
	logic signed [AW-1:0]   nv_c;
	logic [STATE_WIDTH-1:0] ci_new;
	logic [STATE_WIDTH-1:0] cv_new;

	function automatic logic signed [AW-1:0] sat_in(input logic signed [AW-1:0] x);
		logic signed [AW-1:0] r;
		if (x > LIM_A) begin
			r = LIM_A;
		end else if (x < -LIM_A) begin
			r = -LIM_A;
		end else begin
			r = x;
		end
		return r;
	endfunction

	// Halve, truncating toward zero
	function automatic logic signed [AW-1:0] half_tz(input logic signed [AW-1:0] x);
		logic signed [AW-1:0] adj;
		adj = x + AW'(x[AW-1]);
		return adj >>> 1;
	endfunction

	// Clamp a new state into 0 .. 2^STATE_WIDTH - 1
	function automatic logic [STATE_WIDTH-1:0] clamp_st(input logic signed [AW-1:0] x);
		logic signed [AW-1:0] r;
		if (x < 0) begin
			r = '0;
		end else if (x > SMAX) begin
			r = SMAX;
		end else begin
			r = x;
		end
		return r[STATE_WIDTH-1:0];
	endfunction

	//------------------------------------------------------------------
	// Configuration port: writes land on the access phase, reads are muxed
	//------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_l_q <= STEP_L_RST;
			step_c_q <= STEP_C_RST;
			load_g_q <= LOAD_G_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_STEP_L: step_l_q <= pwdata;
				REG_STEP_C: step_c_q <= pwdata;
				REG_LOAD_G: load_g_q <= pwdata;
				REG_NONE:   ;
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_STEP_L: prdata = step_l_q;
			REG_STEP_C: prdata = step_c_q;
			REG_LOAD_G: prdata = load_g_q;
			default:    prdata = 32'd0;
		endcase
	end

	//------------------------------------------------------------------
	// Handshakes
	//------------------------------------------------------------------
	assign in.ready  = (st_q == ST_IDLE);
	assign in_fire   = in.valid && in.ready;
	assign out_fire  = out_valid_q && out.ready;
	// The finished step leaves only once the output register has room
	assign upd_fire  = (st_q == ST_UPD) && (!out_valid_q || out.ready);
	assign out.valid = out_valid_q;
	assign out.i_l   = out_i_q;
	assign out.v_c   = out_v_q;

	//------------------------------------------------------------------
	// Combinational datapath helpers
	//------------------------------------------------------------------
	assign omd  = FRAC_ONE - {1'b0, duty_q};
	assign i0_x = AW'(i0_q);
	assign v0_x = AW'(v0_q);

	// Evaluation point: the start state for k1, half of the last k for k2 and k3,
	// the whole of it for k4
	always_comb begin
		khi_c = (stage_q == 2'd3) ? ki_q : half_tz(ki_q);
		khv_c = (stage_q == 2'd3) ? kv_q : half_tz(kv_q);
		if (stage_q == 2'd0) begin
			pi_c = i0_x;
			pv_c = v0_x;
		end else begin
			pi_c = sat_in(i0_x + khi_c);
			pv_c = sat_in(v0_x + khv_c);
		end
	end

	// One byte of the divide by six on both magnitudes: the partial dividend is
	// below 1536, so a reciprocal multiply gives its exact quotient digit
	always_comb begin
		rti_c = {ri_q, qi_q[DW-1 -: 8]};
		rtv_c = {rv_q, qv_q[DW-1 -: 8]};
		mqi_c = {11'd0, rti_c} * {11'd0, RECIP_SIX};
		mqv_c = {11'd0, rtv_c} * {11'd0, RECIP_SIX};
		qdi_c = mqi_c[20:13];
		qdv_c = mqv_c[20:13];
		sxi_c = {1'b0, qdi_c, 2'b00} + {2'b00, qdi_c, 1'b0};
		sxv_c = {1'b0, qdv_c, 2'b00} + {2'b00, qdv_c, 1'b0};
		rmi_c = rti_c - sxi_c;
		rmv_c = rtv_c - sxv_c;
	end

	always_comb begin
		qsi_c  = signed'(qi_q[AW-1:0]);
		qsv_c  = signed'(qv_q[AW-1:0]);
		ni_c   = i0_x + (negi_q ? -qsi_c : qsi_c);
		nv_c   = v0_x + (negv_q ? -qsv_c : qsv_c);
		ci_new = clamp_st(ni_c);
		cv_new = clamp_st(nv_c);
	end

	//------------------------------------------------------------------
	// Sequencer: next state
	//------------------------------------------------------------------
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (in_fire) st_d = ST_DV;
			ST_DV:   if (mdone) st_d = ST_PT;
			ST_PT:   st_d = ST_LOAD;
			ST_LOAD: if (mdone) st_d = boost_q ? ST_OMV : ST_AB;
			ST_OMV:  if (mdone) st_d = ST_OMI;
			ST_OMI:  if (mdone) st_d = ST_AB;
			ST_AB:   st_d = ST_KI;
			ST_KI:   if (mdone) st_d = ST_KV;
			ST_KV:   if (mdone) st_d = ST_ACC;
			ST_ACC:  st_d = (stage_q == 2'd3) ? ST_DSET : ST_PT;
			ST_DSET: st_d = ST_DIV;
			ST_DIV:  if (cnt_q == CW'(1)) st_d = ST_UPD;
			ST_UPD:  if (upd_fire) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	//------------------------------------------------------------------
	// Sequencer: multiplier requests and operand selection
	//------------------------------------------------------------------
	always_comb begin
		mreq.start = 1'b0;
		mreq.sh    = SH32;
		mreq.sat   = 1'b1;
		mopa       = '0;
		mopb       = 32'd0;
		unique case (st_q)
			ST_DV: begin
				// Duty times supply, not saturated, for the buck drive term
				mreq.start = !issued_q;
				mreq.sh    = SH16;
				mreq.sat   = 1'b0;
				mopa       = AW'(duty_q);
				mopb       = vin_q;
			end
			ST_LOAD: begin
				mreq.start = !issued_q;
				mreq.sh    = SH24;
				mopa       = vp_q;
				mopb       = load_g_q;
			end
			ST_OMV: begin
				mreq.start = !issued_q;
				mreq.sh    = SH16;
				mopa       = vp_q;
				mopb       = 32'(omd);
			end
			ST_OMI: begin
				mreq.start = !issued_q;
				mreq.sh    = SH16;
				mopa       = ci_q;
				mopb       = 32'(omd);
			end
			ST_KI: begin
				mreq.start = !issued_q;
				mopa       = da_q;
				mopb       = step_l_q;
			end
			ST_KV: begin
				mreq.start = !issued_q;
				mopa       = db_q;
				mopb       = step_c_q;
			end
			default: ;
		endcase
	end

	bbrk_mul #(
		.STATE_WIDTH(STATE_WIDTH),
		.AW(AW)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mreq),
		.opa   (mopa),
		.opb   (mopb),
		.done  (mdone),
		.res   (mres)
	);

	//------------------------------------------------------------------
	// Control registers
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			stage_q     <= 2'd0;
			issued_q    <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			i0_q        <= '0;
			v0_q        <= '0;
		end else begin
			st_q <= st_d;
			if (mreq.start) begin
				issued_q <= 1'b1;
			end else if (mdone) begin
				issued_q <= 1'b0;
			end
			if (in_fire) begin
				stage_q <= 2'd0;
			end else if (st_q == ST_ACC) begin
				stage_q <= stage_q + 2'd1;
			end
			if (st_q == ST_DSET) begin
				cnt_q <= CW'(ND);
			end else if (st_q == ST_DIV) begin
				cnt_q <= cnt_q - CW'(1);
			end
			// Commit the step and present it
			if (upd_fire) begin
				i0_q        <= ci_new;
				v0_q        <= cv_new;
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	//------------------------------------------------------------------
	// Datapath registers
	//------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_fire) begin
			duty_q  <= in.duty;
			boost_q <= in.mode;
			vin_q   <= in.v_in;
			si_q    <= '0;
			sv_q    <= '0;
		end
		unique case (st_q)
			ST_DV: if (mdone) dv_q <= mres;
			ST_PT: begin
				ci_q <= pi_c;
				vp_q <= (pv_c < 0) ? '0 : pv_c;
			end
			ST_LOAD: if (mdone) load_q <= mres;
			ST_OMV:  if (mdone) omv_q <= mres;
			ST_OMI:  if (mdone) omi_q <= mres;
			ST_AB: begin
				if (boost_q) begin
					da_q <= sat_in(AW'(vin_q) - omv_q);
					db_q <= sat_in(omi_q - load_q);
				end else begin
					da_q <= sat_in(dv_q - vp_q);
					db_q <= sat_in(ci_q - load_q);
				end
			end
			ST_KI: if (mdone) ki_q <= mres;
			ST_KV: if (mdone) kv_q <= mres;
			ST_ACC: begin
				// Weight k2 and k3 by two
				if ((stage_q == 2'd1) || (stage_q == 2'd2)) begin
					si_q <= si_q + (ki_q <<< 1);
					sv_q <= sv_q + (kv_q <<< 1);
				end else begin
					si_q <= si_q + ki_q;
					sv_q <= sv_q + kv_q;
				end
			end
			ST_DSET: begin
				negi_q <= (si_q < 0);
				negv_q <= (sv_q < 0);
				qi_q   <= DW'(unsigned'((si_q < 0) ? -si_q : si_q));
				qv_q   <= DW'(unsigned'((sv_q < 0) ? -sv_q : sv_q));
				ri_q   <= 3'd0;
				rv_q   <= 3'd0;
			end
			ST_DIV: begin
				ri_q <= rmi_c[2:0];
				rv_q <= rmv_c[2:0];
				qi_q <= {qi_q[DW-9:0], qdi_c};
				qv_q <= {qv_q[DW-9:0], qdv_c};
			end
			ST_UPD: begin
				if (upd_fire) begin
					out_i_q <= 32'(ci_new);
					out_v_q <= 32'(cv_new);
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: sv/bbrk_chk.sv
// Port-level checker for the plant step block, bound to the top level.
module bbrk_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] i_l,
	input logic [31:0] v_c,
	input logic        pready
);

	// Hold a result until it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(i_l) && $stable(v_c))
		else $error("result changed while stalled");

	// Checks that the input drops ready once an item is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while a step is in progress");

	// A step never finishes in the cycle after its item
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared too early");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("configuration port inserted a wait state");

endmodule

bind buck_boost_rk4_plant_step_top bbrk_chk u_bbrk_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in.valid),
	.in_ready (in.ready),
	.out_valid(out.valid),
	.out_ready(out.ready),
	.i_l      (out.i_l),
	.v_c      (out.v_c),
	.pready   (pready)
);
